// ===== rtl/pressure_temp_compensation_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// A property checked at every clock edge outside of reset.
`define PTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ptc assertion failed");

// An implication checked at every clock edge outside of reset.
`define PTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptc implication failed");

`endif

// ===== rtl/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, constants and stage types of the compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned CAL_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DT_W    = 25;
  localparam int unsigned PROD_W  = 42;
  localparam int unsigned DD_W    = 50;
  localparam int unsigned TD_W    = PROD_W - 23;
  localparam int unsigned TEMP_W  = 20;
  localparam int unsigned T2_W    = 18;
  localparam int unsigned SQ_W    = 38;
  localparam int unsigned CORR_W  = 44;
  localparam int unsigned OFF_W   = 46;
  localparam int unsigned SENS_W  = 46;
  localparam int unsigned LO_W    = 23;
  localparam int unsigned HI_W    = SENS_W - LO_W;
  localparam int unsigned PLO_W   = 49;
  localparam int unsigned PHI_W   = 48;
  localparam int unsigned FULL_W  = 72;
  localparam int unsigned X_W     = 53;
  localparam int unsigned PRES_W  = X_W - 15;
  localparam int unsigned TOUT_W  = 15;
  localparam int unsigned POUT_W  = 17;

  localparam int unsigned PTC_LATENCY = 10;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] TEMP_DEEP = TEMP_W'(3500);
  localparam logic signed [TOUT_W-1:0] TEMP_MIN  = TOUT_W'(-4000);
  localparam logic signed [TOUT_W-1:0] TEMP_MAX  = TOUT_W'(8500);
  localparam logic [POUT_W-1:0]        PRES_MIN  = POUT_W'(1000);
  localparam logic [POUT_W-1:0]        PRES_MAX  = POUT_W'(120000);

  typedef enum logic [IDX_W-1:0] {
    REG_PRESSURE_SENS    = 3'd0,
    REG_PRESSURE_OFFSET  = 3'd1,
    REG_SENS_TEMP_COEF   = 3'd2,
    REG_OFFSET_TEMP_COEF = 3'd3,
    REG_REF_TEMPERATURE  = 3'd4,
    REG_TEMP_COEF        = 3'd5,
    REG_SECOND_ORDER     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sens;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sens_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] ref_temperature;
    logic [CAL_W-1:0] temp_coef;
    logic             second_order_en;
  } cal_t;

  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TD_W-1:0]   tdelta;
    logic signed [TEMP_W-1:0] tdeep;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [T2_W-1:0]          t2;
    logic                     cold;
    logic                     deep;
  } coef_t;

  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         d1;
    logic signed [TOUT_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } corr_t;

endpackage

// ===== rtl/ptc_cal_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_cal_regs
// Calibration words and the second-order enable, written through a plain port.
// ----------------------------------------------------------------------------
module ptc_cal_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [ptc_pkg::CAL_W-1:0]  cfg_wdata_i,
  output ptc_pkg::cal_t              cal_o
);

  ptc_pkg::cal_t cal_q, cal_d;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (ptc_pkg::reg_idx_e'(cfg_idx_i))
        ptc_pkg::REG_PRESSURE_SENS:    cal_d.pressure_sens    = cfg_wdata_i;
        ptc_pkg::REG_PRESSURE_OFFSET:  cal_d.pressure_offset  = cfg_wdata_i;
        ptc_pkg::REG_SENS_TEMP_COEF:   cal_d.sens_temp_coef   = cfg_wdata_i;
        ptc_pkg::REG_OFFSET_TEMP_COEF: cal_d.offset_temp_coef = cfg_wdata_i;
        ptc_pkg::REG_REF_TEMPERATURE:  cal_d.ref_temperature  = cfg_wdata_i;
        ptc_pkg::REG_TEMP_COEF:        cal_d.temp_coef        = cfg_wdata_i;
        ptc_pkg::REG_SECOND_ORDER:     cal_d.second_order_en  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{second_order_en: 1'b1, default: '0};
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

// ===== rtl/ptc_coef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_coef
// Stages one to three: temperature delta, the four products on it, and the
// first-order temperature, offset and sensitivity terms.
// ----------------------------------------------------------------------------
module ptc_coef (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure_i,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature_i,
  input  ptc_pkg::cal_t              cal_i,
  output ptc_pkg::coef_t             coef_o
);

  localparam int unsigned DtW   = ptc_pkg::DT_W;
  localparam int unsigned ProdW = ptc_pkg::PROD_W;
  localparam int unsigned DdW   = ptc_pkg::DD_W;
  localparam int unsigned TempW = ptc_pkg::TEMP_W;
  localparam int unsigned OffW  = ptc_pkg::OFF_W;
  localparam int unsigned SensW = ptc_pkg::SENS_W;
  localparam int unsigned T2W   = ptc_pkg::T2_W;

  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic [ptc_pkg::RAW_W-1:0] s1_d1_q, s2_d1_q;
  logic signed [DtW-1:0]   dt_d, dt_q;
  logic signed [ProdW-1:0] p6_d, p6_q, p4_d, p4_q, p3_d, p3_q;
  logic signed [DdW-1:0]   dd_d, dd_q;
  logic signed [ptc_pkg::TD_W-1:0] td;
  ptc_pkg::coef_t          coef_d, coef_q;

  always_comb begin
    dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.ref_temperature, 8'h00});
  end

  always_comb begin
    p6_d = ProdW'(dt_q) * ProdW'($signed({1'b0, cal_i.temp_coef}));
    p4_d = ProdW'(dt_q) * ProdW'($signed({1'b0, cal_i.offset_temp_coef}));
    p3_d = ProdW'(dt_q) * ProdW'($signed({1'b0, cal_i.sens_temp_coef}));
    dd_d = DdW'(dt_q) * DdW'(dt_q);
  end

  always_comb begin
    td            = $signed(p6_q[ProdW-1:23]);
    coef_d.valid  = s2_valid_q;
    coef_d.d1     = s2_d1_q;
    coef_d.tdelta = td;
    coef_d.temp   = TempW'(td) + ptc_pkg::TEMP_REF;
    coef_d.tdeep  = TempW'(td) + ptc_pkg::TEMP_DEEP;
    coef_d.off    = OffW'($signed({1'b0, cal_i.pressure_offset, 16'h0000}))
                  + OffW'($signed(p4_q[ProdW-1:7]));
    coef_d.sens   = SensW'($signed({1'b0, cal_i.pressure_sens, 15'h0000}))
                  + SensW'($signed(p3_q[ProdW-1:8]));
    coef_d.t2     = dd_q[31 +: T2W];
    coef_d.cold   = cal_i.second_order_en & td[ptc_pkg::TD_W-1];
    coef_d.deep   = coef_d.tdeep[TempW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_d1_q <= raw_pressure_i;
    dt_q    <= dt_d;
    s2_d1_q <= s1_d1_q;
    p6_q    <= p6_d;
    p4_q    <= p4_d;
    p3_q    <= p3_d;
    dd_q    <= dd_d;
    coef_q  <= coef_d;
  end

  always_comb begin
    coef_o       = coef_q;
    coef_o.valid = s3_valid_q;
  end

endmodule

// ===== rtl/ptc_corr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_corr
// Stages four to six: squares for the low-temperature correction, the
// correction terms, and the corrected and clamped temperature.
// ----------------------------------------------------------------------------
module ptc_corr (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptc_pkg::coef_t  coef_i,
  output ptc_pkg::corr_t  corr_o
);

  localparam int unsigned SqW   = ptc_pkg::SQ_W;
  localparam int unsigned CorrW = ptc_pkg::CORR_W;
  localparam int unsigned OffW  = ptc_pkg::OFF_W;
  localparam int unsigned SensW = ptc_pkg::SENS_W;
  localparam int unsigned TcW   = ptc_pkg::TEMP_W + 1;
  localparam int unsigned T2W   = ptc_pkg::T2_W;

  logic                       s4_valid_q, s5_valid_q, s6_valid_q;
  ptc_pkg::coef_t             s4_q;
  logic signed [SqW-1:0]      sq_d, sq_q, sq2_d, sq2_q;
  logic [ptc_pkg::RAW_W-1:0]  s5_d1_q;
  logic signed [ptc_pkg::TEMP_W-1:0] s5_temp_q;
  logic signed [OffW-1:0]     s5_off_q;
  logic signed [SensW-1:0]    s5_sens_q;
  logic [T2W-1:0]             t2e_d, t2e_q;
  logic signed [CorrW-1:0]    sq_w, sq2_w, five_sq, seven_sq2, eleven_sq2;
  logic signed [CorrW-1:0]    off2_d, off2_q, sens2_d, sens2_q;
  logic signed [TcW-1:0]      temp_c;
  ptc_pkg::corr_t             corr_d, corr_q;

  always_comb begin
    sq_d  = SqW'(coef_i.tdelta) * SqW'(coef_i.tdelta);
    sq2_d = SqW'(coef_i.tdeep) * SqW'(coef_i.tdeep);
  end

  always_comb begin
    sq_w       = CorrW'(sq_q);
    sq2_w      = CorrW'(sq2_q);
    five_sq    = sq_w + (sq_w <<< 2);
    seven_sq2  = (sq2_w <<< 3) - sq2_w;
    eleven_sq2 = (sq2_w <<< 3) + (sq2_w <<< 1) + sq2_w;
    off2_d     = '0;
    sens2_d    = '0;
    t2e_d      = '0;
    if (s4_q.cold) begin
      t2e_d   = s4_q.t2;
      off2_d  = five_sq >>> 1;
      sens2_d = five_sq >>> 2;
      if (s4_q.deep) begin
        off2_d  = off2_d + seven_sq2;
        sens2_d = sens2_d + (eleven_sq2 >>> 1);
      end
    end
  end

  always_comb begin
    temp_c       = TcW'(s5_temp_q) - TcW'($signed({1'b0, t2e_q}));
    corr_d.valid = s5_valid_q;
    corr_d.d1    = s5_d1_q;
    corr_d.off   = s5_off_q - OffW'(off2_q);
    corr_d.sens  = s5_sens_q - SensW'(sens2_q);
    if (temp_c < TcW'(ptc_pkg::TEMP_MIN)) begin
      corr_d.temp = ptc_pkg::TEMP_MIN;
    end else if (temp_c > TcW'(ptc_pkg::TEMP_MAX)) begin
      corr_d.temp = ptc_pkg::TEMP_MAX;
    end else begin
      corr_d.temp = temp_c[ptc_pkg::TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= coef_i.valid;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q      <= coef_i;
    sq_q      <= sq_d;
    sq2_q     <= sq2_d;
    s5_d1_q   <= s4_q.d1;
    s5_temp_q <= s4_q.temp;
    s5_off_q  <= s4_q.off;
    s5_sens_q <= s4_q.sens;
    t2e_q     <= t2e_d;
    off2_q    <= off2_d;
    sens2_q   <= sens2_d;
    corr_q    <= corr_d;
  end

  always_comb begin
    corr_o       = corr_q;
    corr_o.valid = s6_valid_q;
  end

endmodule

// ===== rtl/ptc_pres.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pres
// Stages seven to ten: the split raw pressure product, its recombination,
// offset removal, scaling and clamping into the result registers.
// ----------------------------------------------------------------------------
module ptc_pres (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptc_pkg::corr_t                     corr_i,
  output logic                               done_o,
  output logic signed [ptc_pkg::TOUT_W-1:0]  temperature_o,
  output logic [ptc_pkg::POUT_W-1:0]         pressure_o
);

  localparam int unsigned LoW   = ptc_pkg::LO_W;
  localparam int unsigned PloW  = ptc_pkg::PLO_W;
  localparam int unsigned PhiW  = ptc_pkg::PHI_W;
  localparam int unsigned FullW = ptc_pkg::FULL_W;
  localparam int unsigned XW    = ptc_pkg::X_W;
  localparam int unsigned PresW = ptc_pkg::PRES_W;
  localparam int unsigned OffW  = ptc_pkg::OFF_W;

  logic                      s7_valid_q, s8_valid_q, s9_valid_q, s10_valid_q;
  logic signed [PloW-1:0]    plo_d, plo_q;
  logic signed [PhiW-1:0]    phi_d, phi_q;
  logic signed [FullW-1:0]   full_d, full_q;
  logic signed [XW-1:0]      x_d, x_q;
  logic signed [PresW-1:0]   pres;
  logic signed [OffW-1:0]    s7_off_q, s8_off_q;
  logic signed [ptc_pkg::TOUT_W-1:0] s7_temp_q, s8_temp_q, s9_temp_q;
  logic signed [ptc_pkg::TOUT_W-1:0] temp_q;
  logic [ptc_pkg::POUT_W-1:0] pres_d, pres_q;

  always_comb begin
    plo_d = PloW'($signed({1'b0, corr_i.d1})) * PloW'($signed({1'b0, corr_i.sens[LoW-1:0]}));
    phi_d = PhiW'($signed({1'b0, corr_i.d1}))
          * PhiW'($signed(corr_i.sens[ptc_pkg::SENS_W-1:LoW]));
  end

  always_comb begin
    full_d = (FullW'(phi_q) <<< LoW) + FullW'(plo_q);
    x_d    = XW'($signed(full_q[FullW-1:21])) - XW'(s8_off_q);
  end

  always_comb begin
    pres = $signed(x_q[XW-1:15]);
    if (pres < PresW'($signed({1'b0, ptc_pkg::PRES_MIN}))) begin
      pres_d = ptc_pkg::PRES_MIN;
    end else if (pres > PresW'($signed({1'b0, ptc_pkg::PRES_MAX}))) begin
      pres_d = ptc_pkg::PRES_MAX;
    end else begin
      pres_d = pres[ptc_pkg::POUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
    end else begin
      s7_valid_q  <= corr_i.valid;
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q     <= plo_d;
    phi_q     <= phi_d;
    s7_off_q  <= corr_i.off;
    s7_temp_q <= corr_i.temp;
    full_q    <= full_d;
    s8_off_q  <= s7_off_q;
    s8_temp_q <= s7_temp_q;
    x_q       <= x_d;
    s9_temp_q <= s8_temp_q;
    temp_q    <= s9_temp_q;
    pres_q    <= pres_d;
  end

  assign done_o        = s10_valid_q;
  assign temperature_o = temp_q;
  assign pressure_o    = pres_q;

endmodule

// ===== rtl/pressure_temp_compensation_core.sv =====
`timescale 1ns / 1ps
// Throughput: one reading pair per cycle; busy_o stays low and start is never refused.
// The rate is set by the ten-stage datapath; each multiplier has a register after it.
// Reset clears all valid bits at once and returns the calibration words to zero
// with the second-order correction enabled. Results cannot be held off.
// ----------------------------------------------------------------------------
// pressure_temp_compensation_core
// Compensated temperature and pressure from raw readings and calibration words.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_pressure_i,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_temperature_i,
  input  logic                               cfg_we_i,
  input  logic [ptc_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [ptc_pkg::CAL_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic signed [ptc_pkg::TOUT_W-1:0]  temperature_o,
  output logic [ptc_pkg::POUT_W-1:0]         pressure_o
);

  ptc_pkg::cal_t  cal;
  ptc_pkg::coef_t coef;
  ptc_pkg::corr_t corr;

  assign busy_o = 1'b0;

  ptc_cal_regs u_cal_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  ptc_coef u_coef (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cal_i             (cal),
    .coef_o            (coef)
  );

  ptc_corr u_corr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .corr_o (corr)
  );

  ptc_pres u_pres (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .corr_i        (corr),
    .done_o        (done_o),
    .temperature_o (temperature_o),
    .pressure_o    (pressure_o)
  );

endmodule

// ===== rtl/ptc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of result timing and result ranges of the core.
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_core_macros.svh"

module ptc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic signed [ptc_pkg::TOUT_W-1:0]  temperature_o,
  input logic [ptc_pkg::POUT_W-1:0]         pressure_o
);

  localparam int unsigned Lat = ptc_pkg::PTC_LATENCY;

  // Every accepted beat yields its result after the fixed latency, and only then.
  `PTC_ASSERT(a_result_follows, (start_i && !busy_o) |-> ##Lat done_o)
  `PTC_ASSERT_IMPL(a_result_caused, done_o, $past(start_i && !busy_o, Lat))
  `PTC_ASSERT_IMPL(a_temp_range, done_o, (temperature_o >= ptc_pkg::TEMP_MIN) && (temperature_o <= ptc_pkg::TEMP_MAX))
  `PTC_ASSERT_IMPL(a_pres_range, done_o, (pressure_o >= ptc_pkg::PRES_MIN) && (pressure_o <= ptc_pkg::PRES_MAX))

endmodule

bind pressure_temp_compensation_core ptc_checker u_ptc_checker (.*);

// ===== sim/tb_pressure_temp_compensation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temp_compensation_core
// Self-checking bench for the compensation core. A short table of directed
// readings covers reset calibration, both cold correction bands, their
// boundaries and saturation. Random phases follow, each with freshly written
// calibration words. Expected results come from an in-bench model or, for some
// directed rows, from the table; they are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_pressure_temp_compensation_core;

  localparam logic [ptc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint WARM_LIMIT = 2000;
  localparam longint DEEP_LIMIT = -1500;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [ptc_pkg::TOUT_W-1:0] temperature;
    logic [ptc_pkg::POUT_W-1:0]        pressure;
  } reading_t;

  typedef struct packed {
    logic [2:0]                cal_set;
    logic [ptc_pkg::RAW_W-1:0] d1;
    logic [ptc_pkg::RAW_W-1:0] d2;
    logic                      typed;
    reading_t                  exp;
  } stim_row_t;

  localparam ptc_pkg::cal_t CAL_SETS [7] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1},
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 1'b1},
    '{16'd40000, 16'd36000, 16'd23000, 16'd23000, 16'd65535, 16'd8192, 1'b1},
    '{16'd40000, 16'd36000, 16'd23000, 16'd23000, 16'd65535, 16'd8192, 1'b0},
    '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1},
    '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd65535, 1'b0},
    '{16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}
  };

  localparam stim_row_t DIRECTED [25] = '{
    '{3'd0, 24'h000000, 24'h000000, 1'b1, '{15'sd2000, 17'd1000}},
    '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{15'sd2000, 17'd1000}},
    '{3'd0, 24'hFFFFFF, 24'h000000, 1'b1, '{15'sd2000, 17'd1000}},
    '{3'd0, 24'h000000, 24'hFFFFFF, 1'b1, '{15'sd2000, 17'd1000}},
    '{3'd1, 24'd9085466, 24'd8569150, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'd9085466, 24'd8566784, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'd9085466, 24'd8566783, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'd8000000, 24'd7974000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'd8000000, 24'd7381000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'hFFFFFF, 24'h000000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd1, 24'h000000, 24'hFFFFFF, 1'b0, '{15'sd0, 17'd0}},
    '{3'd2, 24'd9000000, 24'd16776960, 1'b0, '{15'sd0, 17'd0}},
    '{3'd2, 24'd9000000, 24'd16776959, 1'b0, '{15'sd0, 17'd0}},
    '{3'd2, 24'd9000000, 24'd13192960, 1'b0, '{15'sd0, 17'd0}},
    '{3'd2, 24'd9000000, 24'd13192959, 1'b0, '{15'sd0, 17'd0}},
    '{3'd2, 24'hFFFFFF, 24'h000000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd3, 24'd9000000, 24'd16776959, 1'b0, '{15'sd0, 17'd0}},
    '{3'd3, 24'd9000000, 24'd13192959, 1'b0, '{15'sd0, 17'd0}},
    '{3'd4, 24'hFFFFFF, 24'h000000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '{15'sd0, 17'd0}},
    '{3'd4, 24'h000000, 24'h000000, 1'b0, '{15'sd0, 17'd0}},
    '{3'd5, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '{15'sd0, 17'd0}},
    '{3'd5, 24'h000000, 24'hFFFFFF, 1'b0, '{15'sd0, 17'd0}},
    '{3'd6, 24'hFFFFFF, 24'h000000, 1'b1, '{15'sd2000, 17'd120000}},
    '{3'd6, 24'h000000, 24'h000000, 1'b1, '{15'sd2000, 17'd1000}}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start_i = 1'b0;
  logic                              busy_o;
  logic [ptc_pkg::RAW_W-1:0]         raw_pressure_i = '0;
  logic [ptc_pkg::RAW_W-1:0]         raw_temperature_i = '0;
  logic                              cfg_we_i = 1'b0;
  logic [ptc_pkg::IDX_W-1:0]         cfg_idx_i = '0;
  logic [ptc_pkg::CAL_W-1:0]         cfg_wdata_i = '0;
  logic                              done_o;
  logic signed [ptc_pkg::TOUT_W-1:0] temperature_o;
  logic [ptc_pkg::POUT_W-1:0]        pressure_o;

  ptc_pkg::cal_t cal_now = CAL_SETS[0];
  reading_t      pending_readings [$];
  int            idle_pct = 16;
  int            errors = 0;
  int            cycles = 0;

  pressure_temp_compensation_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .temperature_o     (temperature_o),
    .pressure_o        (pressure_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic reading_t compensate(input ptc_pkg::cal_t c,
                                          input logic [ptc_pkg::RAW_W-1:0] d1,
                                          input logic [ptc_pkg::RAW_W-1:0] d2);
    longint   dt, temp, off, sens, t2, sq, off2, sens2, pres;
    reading_t r;
    dt   = longint'(d2) - longint'(c.ref_temperature) * 256;
    temp = WARM_LIMIT + ((dt * longint'(c.temp_coef)) >>> 23);
    off  = longint'(c.pressure_offset) * 65536
         + ((dt * longint'(c.offset_temp_coef)) >>> 7);
    sens = longint'(c.pressure_sens) * 32768
         + ((dt * longint'(c.sens_temp_coef)) >>> 8);
    if (c.second_order_en && temp < WARM_LIMIT) begin
      t2    = (dt * dt) >>> 31;
      sq    = (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < DEEP_LIMIT) begin
        sq    = (temp - DEEP_LIMIT) * (temp - DEEP_LIMIT);
        off2  = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    pres = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    if (temp < longint'(ptc_pkg::TEMP_MIN)) temp = longint'(ptc_pkg::TEMP_MIN);
    if (temp > longint'(ptc_pkg::TEMP_MAX)) temp = longint'(ptc_pkg::TEMP_MAX);
    if (pres < longint'(ptc_pkg::PRES_MIN)) pres = longint'(ptc_pkg::PRES_MIN);
    if (pres > longint'(ptc_pkg::PRES_MAX)) pres = longint'(ptc_pkg::PRES_MAX);
    r.temperature = ptc_pkg::TOUT_W'(temp);
    r.pressure    = ptc_pkg::POUT_W'(pres);
    return r;
  endfunction

  task automatic send_beat(input logic [ptc_pkg::RAW_W-1:0] d1,
                           input logic [ptc_pkg::RAW_W-1:0] d2,
                           input reading_t exp);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i           <= 1'b0;
      raw_pressure_i    <= ptc_pkg::RAW_W'($urandom);
      raw_temperature_i <= ptc_pkg::RAW_W'($urandom);
      @(posedge clk_i);
    end
    start_i           <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (busy_o);
    pending_readings.push_back(exp);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [ptc_pkg::IDX_W-1:0] idx,
                           input logic [ptc_pkg::CAL_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_cal(input ptc_pkg::cal_t c);
    logic [ptc_pkg::CAL_W-1:0] en_word;
    en_word    = ptc_pkg::CAL_W'($urandom);
    en_word[0] = c.second_order_en;
    write_reg(ptc_pkg::REG_PRESSURE_SENS, c.pressure_sens);
    write_reg(ptc_pkg::REG_PRESSURE_OFFSET, c.pressure_offset);
    write_reg(ptc_pkg::REG_SENS_TEMP_COEF, c.sens_temp_coef);
    write_reg(ptc_pkg::REG_OFFSET_TEMP_COEF, c.offset_temp_coef);
    write_reg(ptc_pkg::REG_REF_TEMPERATURE, c.ref_temperature);
    write_reg(ptc_pkg::REG_TEMP_COEF, c.temp_coef);
    write_reg(ptc_pkg::REG_SECOND_ORDER, en_word);
    write_reg(REG_UNUSED, ptc_pkg::CAL_W'($urandom));
    cfg_we_i <= 1'b0;
    cal_now = c;
  endtask

  always @(posedge clk_i) begin
    reading_t exp;
    if (rst_ni && done_o) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no reading pending: temperature %0d, pressure %0d",
               temperature_o, pressure_o);
        errors++;
      end else begin
        exp = pending_readings.pop_front();
        if (temperature_o !== exp.temperature) begin
          $error("temperature mismatch: expected %0d, actual %0d",
                 exp.temperature, temperature_o);
          errors++;
        end
        if (pressure_o !== exp.pressure) begin
          $error("pressure mismatch: expected %0d, actual %0d", exp.pressure, pressure_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int                        cur_set;
    ptc_pkg::cal_t             c;
    logic [ptc_pkg::RAW_W-1:0] d1, d2;
    longint                    center, span;
    cur_set = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (int'(DIRECTED[i].cal_set) != cur_set) begin
        wait_drained();
        cur_set = int'(DIRECTED[i].cal_set);
        program_cal(CAL_SETS[cur_set]);
      end
      send_beat(DIRECTED[i].d1, DIRECTED[i].d2,
                DIRECTED[i].typed ? DIRECTED[i].exp
                                  : compensate(cal_now, DIRECTED[i].d1, DIRECTED[i].d2));
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      idle_pct = (p < PHASES / 3) ? 16 : (p < 2 * PHASES / 3) ? 87 : 0;
      c.pressure_sens    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : ptc_pkg::CAL_W'($urandom);
      c.pressure_offset  = ($urandom_range(0, 9) == 0) ? 16'h0000 : ptc_pkg::CAL_W'($urandom);
      c.sens_temp_coef   = ($urandom_range(0, 9) == 0) ? 16'hFFFF : ptc_pkg::CAL_W'($urandom);
      c.offset_temp_coef = ($urandom_range(0, 9) == 0) ? 16'h0000 : ptc_pkg::CAL_W'($urandom);
      c.ref_temperature  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : ptc_pkg::CAL_W'($urandom);
      c.temp_coef        = ($urandom_range(0, 9) == 0) ? 16'h0000 : ptc_pkg::CAL_W'($urandom);
      c.second_order_en  = ($urandom_range(0, 3) != 0);
      program_cal(c);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0: d1 = '0;
          1: d1 = '1;
          default: d1 = ptc_pkg::RAW_W'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0) begin
          d2 = ptc_pkg::RAW_W'($urandom);
        end else begin
          // Readings near the reference keep the temperature around both thresholds.
          center = longint'(cal_now.ref_temperature) * 256;
          span   = longint'(1) << $urandom_range(0, 23);
          center = center + longint'($urandom_range(0, 32'(2 * span))) - span;
          if (center < 0) center = 0;
          if (center > 64'hFFFFFF) center = 64'hFFFFFF;
          d2 = ptc_pkg::RAW_W'(center);
        end
        if ($urandom_range(0, 99) == 0) wait_drained();
        send_beat(d1, d2, compensate(cal_now, d1, d2));
      end
    end

    wait_drained();
    repeat (ptc_pkg::PTC_LATENCY + 5) @(posedge clk_i);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_cal_regs.sv
rtl/ptc_coef.sv
rtl/ptc_corr.sv
rtl/ptc_pres.sv
rtl/pressure_temp_compensation_core.sv
rtl/ptc_checker.sv
sim/tb_pressure_temp_compensation_core.sv
